// ===== rtl/core/bpsd_pkg.sv =====
// shared types and constants of the button press series decoder
package bpsd_pkg;

   localparam int ADC_W   = 12;
   localparam int TPS_W   = 10;
   localparam int CNT_W   = 8;
   localparam int TMR_W   = 16;
   localparam int NUM_W   = 16;
   localparam int HALF_W  = 9;
   localparam int FIVE_W  = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_THRESHOLD  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_SECOND = 1'd1;

   localparam logic [ADC_W-1:0]  THRESHOLD_RESET = 12'd1000;
   localparam logic [TMR_W-1:0]  LIMIT_RESET     = 16'd6000;
   localparam logic [HALF_W-1:0] HALF_RESET      = 9'd50;
   localparam logic [FIVE_W-1:0] FIVE_RESET      = 13'd500;

   typedef struct packed {
      logic             was_pressed;
      logic [CNT_W-1:0] press_counter;
      logic [TMR_W-1:0] press_timer;
      logic [TMR_W-1:0] release_timer;
      logic [CNT_W-1:0] series_counter;
   } tick_state_type;

   typedef struct packed {
      tick_state_type nxt;
      logic           pressed;
      logic           eval;
      logic           clr;
      logic           latch;
   } tick_result_type;

   typedef struct packed {
      logic [ADC_W-1:0]  threshold;
      logic [TMR_W-1:0]  limit;
      logic [HALF_W-1:0] half;
      logic [FIVE_W-1:0] five;
   } tick_cfg_type;

endpackage

// ===== rtl/core/bpsd_if.sv =====
// handshake channels of the button press series decoder
interface bpsd_req_if;
   logic                      valid;
   logic                      ready;
   logic [bpsd_pkg::ADC_W-1:0] adc_sample;
   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);
endinterface

interface bpsd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       pressed;
   logic [bpsd_pkg::CNT_W-1:0] press_count;
   logic [bpsd_pkg::TMR_W-1:0] press_ticks;
   logic [bpsd_pkg::TMR_W-1:0] release_ticks;
   logic [bpsd_pkg::CNT_W-1:0] series_count;
   logic [bpsd_pkg::NUM_W-1:0] entered_number;
   logic                       series_done;
   modport source (output valid, output pressed, output press_count, output press_ticks,
                   output release_ticks, output series_count, output entered_number,
                   output series_done, input ready);
   modport sink (input valid, input pressed, input press_count, input press_ticks,
                 input release_ticks, input series_count, input entered_number,
                 input series_done, output ready);
endinterface

interface bpsd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bpsd_pkg::CSR_IDX_W-1:0]  index;
   logic [bpsd_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bpsd_tick.sv =====
// per-tick update of press detection, timers and counters
module bpsd_tick #(
   parameter int DIGITS = 4
) (
   input  logic [bpsd_pkg::ADC_W-1:0] sample,
   input  bpsd_pkg::tick_cfg_type     cfg,
   input  bpsd_pkg::tick_state_type   cur,
   output bpsd_pkg::tick_result_type  res
);
   import bpsd_pkg::*;

   always_comb begin
      tick_state_type n;
      logic           p;
      logic           ev;
      logic           cl;
      n  = cur;
      p  = (sample < cfg.threshold);
      ev = 1'b0;
      cl = 1'b0;
      if (p) begin
         if (!cur.was_pressed) begin
            n.release_timer = '0;
            n.press_counter = cur.press_counter + CNT_W'(1);
            n.press_timer   = '0;
         end
         if (n.press_timer < cfg.limit) begin
            n.press_timer = n.press_timer + TMR_W'(1);
         end
      end else begin
         if (n.release_timer < cfg.limit) begin
            n.release_timer = n.release_timer + TMR_W'(1);
         end
         if (n.release_timer == TMR_W'(cfg.half)) begin
            ev = 1'b1;
            n.series_counter = cur.series_counter + CNT_W'(1);
            n.press_counter  = '0;
         end
         // clear check runs after the evaluation on the same tick
         if (n.release_timer == TMR_W'(cfg.five)) begin
            cl = 1'b1;
            n.series_counter = '0;
            n.press_timer    = '0;
         end
      end
      n.was_pressed = p;
      res.nxt     = n;
      res.pressed = p;
      res.eval    = ev;
      res.clr     = cl;
      res.latch   = ev && !cl && ((cur.series_counter + CNT_W'(1)) == CNT_W'(DIGITS));
   end

endmodule

// ===== rtl/core/bpsd_dec_acc.sv =====
// shared multiply-by-ten and add unit for the decimal value, one digit per cycle while step is high
module bpsd_dec_acc (
   input  logic                       clock,
   input  logic                       step,
   input  logic                       first,
   input  logic [bpsd_pkg::CNT_W-1:0] digit,
   output logic [bpsd_pkg::NUM_W-1:0] acc
);
   import bpsd_pkg::*;

   logic [NUM_W-1:0] acc_ff;
   logic [NUM_W-1:0] acc_in;
   logic [NUM_W-1:0] base;

   assign base   = first ? '0 : acc_ff;
   // v*10 as v*8 + v*2, wrapping at the accumulator width
   assign acc_in = {base[NUM_W-4:0], 3'b000} + {base[NUM_W-2:0], 1'b0} + NUM_W'(digit);

   always_ff @(posedge clock) begin
      if (step) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/core/button_press_series_decoder.sv =====
// top level of the button press series decoder
//
// usage: one item on req_ch carries one converter sample (one tick). for every
// item exactly one status item leaves on rsp_ch: pressed flag, press count,
// press and release timers, series count, entered number and series_done.
// csr_ch writes the press threshold (index 0) and ticks per second (index 1);
// it is always ready and the timer limits are derived from ticks per second
// at the write. the user must see that configuration is written while no item
// is in flight; the block does not enforce it. an item passes the accept,
// update and output load steps; a tick that closes the DIGITS-th series adds
// an accumulate step in which one multiply-by-ten/add unit folds the history
// into the entered number, one digit per cycle. req_ch.ready is low from
// accept until the result is loaded into the output register, so one item is
// in work at a time. rsp_ch holds its item while ready is low; a finished
// item then waits in the output stage and the next item is accepted as soon
// as the output register frees. reset clears all counters, timers, history
// and the number and restores threshold 1000 and 100 ticks per second.
module button_press_series_decoder #(
   parameter int DIGITS = 4
) (
   input  logic            clock,
   input  logic            reset,
   bpsd_req_if.sink        req_ch,
   bpsd_rsp_if.source      rsp_ch,
   bpsd_csr_if.sink        csr_ch
);
   import bpsd_pkg::*;

   localparam int IDX_W = (DIGITS > 2) ? $clog2(DIGITS) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_ACC    = 2'd2;
   localparam logic [1:0] ST_OUT    = 2'd3;

   logic [1:0]        state_ff, state_in;
   tick_cfg_type      cfg_ff, cfg_in;
   tick_state_type    tst_ff, tst_in;
   tick_result_type   tres;
   logic [CNT_W-1:0]  hist_ff [DIGITS];
   logic [CNT_W-1:0]  hist_in [DIGITS];
   logic [NUM_W-1:0]  latched_ff, latched_in;
   logic [ADC_W-1:0]  sample_ff;
   logic              pressed_ff, done_ff, latch_pend_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [NUM_W-1:0]  acc;
   logic              acc_step;
   logic              out_free;
   logic [TPS_W-1:0]  tps;

   logic              rsp_valid_ff;
   logic              rsp_pressed_ff;
   logic [CNT_W-1:0]  rsp_press_count_ff;
   logic [TMR_W-1:0]  rsp_press_ticks_ff;
   logic [TMR_W-1:0]  rsp_release_ticks_ff;
   logic [CNT_W-1:0]  rsp_series_count_ff;
   logic [NUM_W-1:0]  rsp_entered_number_ff;
   logic              rsp_series_done_ff;

   bpsd_tick #(.DIGITS(DIGITS)) u_tick (
      .sample (sample_ff),
      .cfg    (cfg_ff),
      .cur    (tst_ff),
      .res    (tres)
   );

   assign acc_step = (state_ff == ST_ACC);

   bpsd_dec_acc u_acc (
      .clock (clock),
      .step  (acc_step),
      .first (idx_ff == '0),
      .digit (hist_ff[idx_ff]),
      .acc   (acc)
   );

   // configuration
   assign csr_ch.ready = 1'b1;
   assign tps          = csr_ch.data[TPS_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_PRESS_THRESHOLD: begin
               cfg_in.threshold = csr_ch.data[ADC_W-1:0];
            end
            CSR_TICKS_PER_SECOND: begin
               cfg_in.limit = TMR_W'({tps, 6'b0}) - TMR_W'({tps, 2'b0});
               cfg_in.half  = tps[TPS_W-1:1];
               cfg_in.five  = FIVE_W'({tps, 2'b0}) + FIVE_W'(tps);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      tst_in     = tst_ff;
      hist_in    = hist_ff;
      latched_in = latched_ff;
      idx_in     = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            tst_in = tres.nxt;
            if (tres.eval) begin
               for (int k = 0; k < DIGITS - 1; k++) begin
                  hist_in[k] = hist_ff[k + 1];
               end
               hist_in[DIGITS-1] = tst_ff.press_counter;
            end
            if (tres.clr) begin
               for (int k = 0; k < DIGITS; k++) begin
                  hist_in[k] = '0;
               end
               latched_in = '0;
            end
            idx_in   = '0;
            state_in = tres.latch ? ST_ACC : ST_OUT;
         end
         ST_ACC: begin
            idx_in = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(DIGITS - 1)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               if (latch_pend_ff) begin
                  latched_in = acc;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cfg_ff.threshold <= THRESHOLD_RESET;
         cfg_ff.limit     <= LIMIT_RESET;
         cfg_ff.half      <= HALF_RESET;
         cfg_ff.five      <= FIVE_RESET;
         tst_ff           <= '0;
         latched_ff       <= '0;
         idx_ff           <= '0;
         latch_pend_ff    <= 1'b0;
         done_ff          <= 1'b0;
         pressed_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         for (int k = 0; k < DIGITS; k++) begin
            hist_ff[k] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         cfg_ff     <= cfg_in;
         tst_ff     <= tst_in;
         hist_ff    <= hist_in;
         latched_ff <= latched_in;
         idx_ff     <= idx_in;
         if (state_ff == ST_UPDATE) begin
            latch_pend_ff <= tres.latch;
            done_ff       <= tres.eval;
            pressed_ff    <= tres.pressed;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         sample_ff <= req_ch.adc_sample;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_pressed_ff        <= pressed_ff;
         rsp_press_count_ff    <= tst_ff.press_counter;
         rsp_press_ticks_ff    <= tst_ff.press_timer;
         rsp_release_ticks_ff  <= tst_ff.release_timer;
         rsp_series_count_ff   <= tst_ff.series_counter;
         rsp_entered_number_ff <= latch_pend_ff ? acc : latched_ff;
         rsp_series_done_ff    <= done_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.pressed        = rsp_pressed_ff;
   assign rsp_ch.press_count    = rsp_press_count_ff;
   assign rsp_ch.press_ticks    = rsp_press_ticks_ff;
   assign rsp_ch.release_ticks  = rsp_release_ticks_ff;
   assign rsp_ch.series_count   = rsp_series_count_ff;
   assign rsp_ch.entered_number = rsp_entered_number_ff;
   assign rsp_ch.series_done    = rsp_series_done_ff;

endmodule

// ===== rtl/core/bpsd_checker.sv =====
// port-level assertions for the button press series decoder and their bind
module bpsd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_pressed,
   input logic [bpsd_pkg::CNT_W-1:0] rsp_press_count,
   input logic [bpsd_pkg::TMR_W-1:0] rsp_release_ticks,
   input logic [bpsd_pkg::NUM_W-1:0] rsp_entered_number,
   input logic                       rsp_series_done
);
   import bpsd_pkg::*;

   // a stalled result item keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_press_count)
         && $stable(rsp_release_ticks) && $stable(rsp_entered_number))
      else $error("stalled result item changed");

   // one item in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in work");

   // a series is only evaluated on a released tick and leaves an empty count
   a_done_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_series_done |-> !rsp_pressed && rsp_press_count == '0)
      else $error("series evaluated on a pressed tick or count not cleared");

   // the press edge clears the release timer and it holds while pressed
   a_pressed_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pressed |-> rsp_release_ticks == '0)
      else $error("release timer nonzero while pressed");

endmodule

bind button_press_series_decoder bpsd_checker u_bpsd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_pressed        (rsp_ch.pressed),
   .rsp_press_count    (rsp_ch.press_count),
   .rsp_release_ticks  (rsp_ch.release_ticks),
   .rsp_entered_number (rsp_ch.entered_number),
   .rsp_series_done    (rsp_ch.series_done)
);

// ===== bench/button_press_series_decoder_tb.sv =====
// self-checking testbench of the button press series decoder
module button_press_series_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bpsd_pkg::*;

   localparam int NUM_DIGITS   = 4;
   localparam int ADC_MAX      = 2**ADC_W - 1;
   localparam int RANDOM_TICKS = 850;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int SHOWN_ERRORS = 20;
   localparam int SETTLE       = 8;

   typedef struct packed {
      logic             pressed;
      logic [CNT_W-1:0] press_count;
      logic [TMR_W-1:0] press_ticks;
      logic [TMR_W-1:0] release_ticks;
      logic [CNT_W-1:0] series_count;
      logic [NUM_W-1:0] entered_number;
      logic             series_done;
   } status_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpsd_req_if req_ch ();
   bpsd_rsp_if rsp_ch ();
   bpsd_csr_if csr_ch ();

   button_press_series_decoder #(.DIGITS(NUM_DIGITS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder state as predicted from the accepted ticks
   logic [ADC_W-1:0] cfg_threshold;
   logic [TPS_W-1:0] cfg_tps;
   logic             was_down;
   logic [CNT_W-1:0] tap_count;
   logic [TMR_W-1:0] hold_timer;
   logic [TMR_W-1:0] idle_timer;
   logic [CNT_W-1:0] digit_q [NUM_DIGITS];
   logic [CNT_W-1:0] series_total;
   logic [NUM_W-1:0] entry_number;

   status_t status_q [$];

   int ticks_sent    = 0;
   int items_checked = 0;
   int series_closed = 0;
   int mismatches    = 0;
   int cycle_count   = 0;
   int rsp_hold      = 0;
   bit steady        = 1'b0;  // when set, neither side idles

   function automatic void reset_decoder();
      cfg_threshold = THRESHOLD_RESET;
      cfg_tps       = TPS_W'(100);
      was_down      = 1'b0;
      tap_count     = '0;
      hold_timer    = '0;
      idle_timer    = '0;
      foreach (digit_q[k]) digit_q[k] = '0;
      series_total  = '0;
      entry_number  = '0;
   endfunction

   function automatic status_t decode_tick(input logic [ADC_W-1:0] sample);
      status_t          s;
      int unsigned      limit;
      int unsigned      half;
      int unsigned      five;
      logic [NUM_W-1:0] value;
      logic             down;
      limit = cfg_tps * 60;
      half  = cfg_tps / 2;
      five  = cfg_tps * 5;
      down  = sample < cfg_threshold;
      s     = '0;
      if (down) begin
         if (!was_down) begin
            idle_timer = '0;
            tap_count  = tap_count + 1'b1;
            hold_timer = '0;
         end
         if (hold_timer < limit) hold_timer = hold_timer + 1'b1;
      end else begin
         if (idle_timer < limit) idle_timer = idle_timer + 1'b1;
         if (idle_timer == half) begin
            for (int k = 0; k < NUM_DIGITS - 1; k++) digit_q[k] = digit_q[k + 1];
            digit_q[NUM_DIGITS - 1] = tap_count;
            value = '0;
            // each step wraps at 16 bits
            for (int k = 0; k < NUM_DIGITS; k++) value = value * 10 + digit_q[k];
            series_total = series_total + 1'b1;
            if (series_total == NUM_DIGITS) entry_number = value;
            tap_count     = '0;
            s.series_done = 1'b1;
         end
         if (idle_timer == five) begin
            foreach (digit_q[k]) digit_q[k] = '0;
            series_total = '0;
            entry_number = '0;
            hold_timer   = '0;
         end
      end
      was_down         = down;
      s.pressed        = down;
      s.press_count    = tap_count;
      s.press_ticks    = hold_timer;
      s.release_ticks  = idle_timer;
      s.series_count   = series_total;
      s.entered_number = entry_number;
      return s;
   endfunction

   function automatic logic [ADC_W-1:0] down_sample();
      if (cfg_threshold == 0) return '0;
      return $urandom_range(0, cfg_threshold - 1);
   endfunction

   function automatic logic [ADC_W-1:0] up_sample();
      return $urandom_range(cfg_threshold, ADC_MAX);
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
         $display("tb: mismatch on %s at status item %0d: got %0d, expected %0d",
                  what, items_checked, got, want);
   endtask

   task automatic send_sample(input logic [ADC_W-1:0] sample);
      while (!steady && $urandom_range(0, 99) < 15) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.adc_sample <= sample;
      do @(posedge clock); while (!req_ch.ready);
      status_q.push_back(decode_tick(sample));
      ticks_sent++;
      @(negedge clock);
   endtask

   // wait until every status item is back and the block has gone quiet
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      drain_block();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      if (index == CSR_PRESS_THRESHOLD)
         cfg_threshold = value;
      else
         cfg_tps = value[TPS_W-1:0];
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_steady(input bit on);
      drain_block();
      @(posedge clock);
      steady = on;
      @(negedge clock);
   endtask

   // taps presses with short gaps, then rest released ticks
   task automatic enter_digit(input int taps, input int rest);
      int gap_max;
      gap_max = (cfg_tps / 2 > 1) ? cfg_tps / 2 - 1 : 1;
      for (int i = 0; i < taps; i++) begin
         repeat ($urandom_range(1, 3)) send_sample(down_sample());
         if (i != taps - 1)
            repeat ($urandom_range(1, gap_max)) send_sample(up_sample());
      end
      repeat (rest) send_sample(up_sample());
   endtask

   // one press and five released seconds at one tick per second wipe the entry
   task automatic clear_entry();
      write_reg(CSR_TICKS_PER_SECOND, 12'd1);
      send_sample(down_sample());
      repeat (5) send_sample(up_sample());
   endtask

   task automatic test_threshold_edges();
      send_sample(12'd0);
      send_sample(12'd999);
      send_sample(12'd1000);
      send_sample(ADC_W'(ADC_MAX));
      write_reg(CSR_PRESS_THRESHOLD, 12'd0);
      send_sample(12'd0);
      send_sample(ADC_W'(ADC_MAX));
      write_reg(CSR_PRESS_THRESHOLD, ADC_W'(ADC_MAX));
      send_sample(ADC_W'(ADC_MAX - 1));
      send_sample(ADC_W'(ADC_MAX));
      send_sample(12'd0);
      write_reg(CSR_PRESS_THRESHOLD, THRESHOLD_RESET);
   endtask

   task automatic test_number_latch();
      clear_entry();
      write_reg(CSR_TICKS_PER_SECOND, 12'd4);
      enter_digit(2, 2);
      enter_digit(1, 2);
      enter_digit(3, 2);
      enter_digit(1, 2);
      // lower rate so the clear point lands three ticks later
      write_reg(CSR_TICKS_PER_SECOND, 12'd1);
      repeat (3) send_sample(up_sample());
   endtask

   task automatic test_tiny_rates();
      write_reg(CSR_TICKS_PER_SECOND, 12'd4);
      repeat (6) send_sample(down_sample());
      // press timer now sits above a zero limit and must hold
      write_reg(CSR_TICKS_PER_SECOND, 12'd0);
      repeat (2) send_sample(down_sample());
      write_reg(CSR_TICKS_PER_SECOND, 12'd4);
      repeat (3) send_sample(up_sample());
      write_reg(CSR_TICKS_PER_SECOND, 12'd0);
      repeat (2) send_sample(up_sample());
      // zero rate: every released tick evaluates and clears
      send_sample(down_sample());
      repeat (2) send_sample(up_sample());
      write_reg(CSR_TICKS_PER_SECOND, 12'd1023);
      send_sample(down_sample());
      send_sample(up_sample());
   endtask

   task automatic test_timer_saturation();
      write_reg(CSR_TICKS_PER_SECOND, 12'd1);
      repeat (62) send_sample(down_sample());
      repeat (62) send_sample(up_sample());
   endtask

   // big first digit overflows the decimal sum, last digit wraps the press count
   task automatic test_count_wrap();
      clear_entry();
      write_reg(CSR_TICKS_PER_SECOND, 12'd4);
      set_steady(1'b1);
      enter_digit(70, 2);
      enter_digit(1, 2);
      enter_digit(1, 2);
      repeat (258) begin
         send_sample(down_sample());
         send_sample(up_sample());
      end
      send_sample(up_sample());
      set_steady(1'b0);
   endtask

   // series count wraps and the fourth series latches a second time
   task automatic test_series_wrap();
      clear_entry();
      write_reg(CSR_TICKS_PER_SECOND, 12'd2);
      repeat (252) begin
         send_sample(down_sample());
         send_sample(up_sample());
      end
      write_reg(CSR_TICKS_PER_SECOND, 12'd4);
      repeat (8) enter_digit($urandom_range(2, 3), 2);
   endtask

   task automatic test_backpressure();
      drain_block();
      @(posedge clock);
      rsp_hold = 200;
      @(negedge clock);
      repeat (16) send_sample($urandom_range(0, ADC_MAX));
      drain_block();
   endtask

   task automatic test_random_entries();
      int first;
      int pick;
      int stop;
      int taps;
      int half;
      int five;
      int hi;
      first = ticks_sent;
      while (ticks_sent - first < RANDOM_TICKS) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            write_reg(CSR_PRESS_THRESHOLD,
                      (pick < 2) ? $urandom_range(1, ADC_MAX) : $urandom_range(300, 3800));
            write_reg(CSR_TICKS_PER_SECOND,
                      (pick < 6) ? $urandom_range(4, 8) : $urandom_range(2, 12));
         end else if (pick < 22) begin
            repeat ($urandom_range(1, 8)) send_sample($urandom_range(0, ADC_MAX));
         end else begin
            half = cfg_tps / 2;
            five = cfg_tps * 5;
            hi   = (half + 4 < five) ? half + 4 : five - 1;
            if (hi < half) hi = half;
            // now and then an entry is abandoned before the last digit
            stop = ($urandom_range(0, 4) == 0) ? $urandom_range(1, NUM_DIGITS - 1) : NUM_DIGITS;
            for (int k = 0; k < stop; k++) begin
               taps = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 9);
               if (k < stop - 1)
                  enter_digit(taps, $urandom_range(half, hi));
               else
                  enter_digit(taps, $urandom_range(0, 1) ? five : half);
            end
         end
      end
   endtask

   always @(posedge clock) begin : check_status
      status_t got;
      status_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.pressed        = rsp_ch.pressed;
         got.press_count    = rsp_ch.press_count;
         got.press_ticks    = rsp_ch.press_ticks;
         got.release_ticks  = rsp_ch.release_ticks;
         got.series_count   = rsp_ch.series_count;
         got.entered_number = rsp_ch.entered_number;
         got.series_done    = rsp_ch.series_done;
         if (status_q.size() == 0) begin
            report_mismatch("status item with nothing expected", 0, 0);
         end else begin
            want = status_q.pop_front();
            items_checked++;
            if (got.pressed !== want.pressed)
               report_mismatch("pressed", got.pressed, want.pressed);
            if (got.press_count !== want.press_count)
               report_mismatch("press_count", got.press_count, want.press_count);
            if (got.press_ticks !== want.press_ticks)
               report_mismatch("press_ticks", got.press_ticks, want.press_ticks);
            if (got.release_ticks !== want.release_ticks)
               report_mismatch("release_ticks", got.release_ticks, want.release_ticks);
            if (got.series_count !== want.series_count)
               report_mismatch("series_count", got.series_count, want.series_count);
            if (got.entered_number !== want.entered_number)
               report_mismatch("entered_number", got.entered_number, want.entered_number);
            if (got.series_done !== want.series_done)
               report_mismatch("series_done", got.series_done, want.series_done);
            if (want.series_done) series_closed++;
         end
      end
   end

   initial begin : rsp_side
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 15);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("tb: no progress after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
   end

   initial begin : run
      req_ch.valid      = 1'b0;
      req_ch.adc_sample = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = '0;
      csr_ch.data       = '0;
      reset_decoder();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_threshold_edges();
      test_number_latch();
      test_tiny_rates();
      test_timer_saturation();
      test_count_wrap();
      test_series_wrap();
      test_backpressure();
      test_random_entries();

      drain_block();
      repeat (20) @(posedge clock);
      $display("tb: %0d ticks checked, %0d series closed, thresholds 0..4095, rates 0..1023",
               items_checked, series_closed);
      $display("tb: %0d mismatches", mismatches);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
